### rtl/core/fmtsr_pkg.sv
// ----------------------------------------------------------------------------
// fmtsr_pkg
// Shared types and constants for the FM chip timer and status register unit.
// ----------------------------------------------------------------------------
package fmtsr_pkg;

  localparam int unsigned TIME_BITS = 40;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned REG_W     = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = PERIOD_W + 9;

  typedef enum logic [2:0] {
    MODE_ADDR    = 3'd0,
    MODE_ADDR_HI = 3'd1,
    MODE_DATA    = 3'd2,
    MODE_STATUS  = 3'd3,
    MODE_READ_HI = 3'd4,
    MODE_TICK    = 3'd5
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_T1_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T2_PERIOD = 2'd1;

  localparam logic [REG_W-1:0] REG_T1_PRESET = 9'h002;
  localparam logic [REG_W-1:0] REG_T2_PRESET = 9'h003;
  localparam logic [REG_W-1:0] REG_TIMER_CTL = 9'h004;
  localparam logic [REG_W-1:0] REG_HI_BANK   = 9'h100;

  localparam logic [PERIOD_W-1:0] T1_PERIOD_RST = 16'd80;
  localparam logic [PERIOD_W-1:0] T2_PERIOD_RST = 16'd320;

  localparam logic [BYTE_W-1:0] STS_IRQ     = 8'h80;
  localparam logic [BYTE_W-1:0] STS_T1_FLAG = 8'h40;
  localparam logic [BYTE_W-1:0] STS_T2_FLAG = 8'h20;
  localparam logic [BYTE_W-1:0] HI_READ_VAL = 8'hff;

  localparam int unsigned CTL_STOP_BIT  = 7;
  localparam int unsigned CTL_T1_MASK   = 6;
  localparam int unsigned CTL_T2_MASK   = 5;
  localparam int unsigned CTL_T1_ENABLE = 0;
  localparam int unsigned CTL_T2_ENABLE = 1;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef struct packed {
    logic [2:0]          mode;
    logic [BYTE_W-1:0]   data_byte;
    logic [PERIOD_W-1:0] elapsed_us;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              forward_valid;
    logic [REG_W-1:0]  forward_register;
    logic [BYTE_W-1:0] forward_data;
  } result_t;

  typedef struct packed {
    logic                 wr;
    logic [CFG_IDX_W-1:0] index;
    logic [PERIOD_W-1:0]  data;
  } cfg_wr_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

endpackage

### rtl/core/fmtsr_in_stage.sv
// ----------------------------------------------------------------------------
// fmtsr_in_stage
// Input register: holds one accepted transaction until the core consumes it.
// ----------------------------------------------------------------------------
module fmtsr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fmtsr_pkg::item_t item_i,
  input  logic            consume_i,
  output logic            item_valid_o,
  output fmtsr_pkg::item_t item_o
);

  logic             valid_q, valid_d;
  fmtsr_pkg::item_t item_q;
  logic             load;

  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/core/fmtsr_core.sv
// ----------------------------------------------------------------------------
// fmtsr_core
// Register latch, timer presets/enables/expiry, time base and status decode.
// ----------------------------------------------------------------------------
module fmtsr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmtsr_pkg::cfg_wr_t cfg_i,
  input  logic               step_i,
  input  fmtsr_pkg::item_t   item_i,
  output fmtsr_pkg::result_t result_o
);

  logic [fmtsr_pkg::PERIOD_W-1:0]  per1_q, per2_q;
  logic [fmtsr_pkg::REG_W-1:0]     latch_q, latch_d;
  logic [fmtsr_pkg::TIME_BITS-1:0] time_q, time_d;
  logic [fmtsr_pkg::BYTE_W-1:0]    pre1_q, pre1_d, pre2_q, pre2_d;
  logic                            on1_q, on1_d, on2_q, on2_d;
  logic [fmtsr_pkg::TIME_BITS-1:0] exp1_q, exp1_d, exp2_q, exp2_d;
  logic [fmtsr_pkg::PROD_W-1:0]    prod1, prod2;
  logic [fmtsr_pkg::TIME_BITS-1:0] new_exp1, new_exp2;
  logic [fmtsr_pkg::BYTE_W-1:0]    b;
  fmtsr_pkg::result_t              res;

  assign b = item_i.data_byte;

  assign prod1 = fmtsr_pkg::PROD_W'((9'd256 - {1'b0, pre1_d}) * per1_q);
  assign prod2 = fmtsr_pkg::PROD_W'((9'd256 - {1'b0, pre2_d}) * per2_q);
  assign new_exp1 = fmtsr_pkg::sat_add(time_q, fmtsr_pkg::TIME_BITS'(prod1));
  assign new_exp2 = fmtsr_pkg::sat_add(time_q, fmtsr_pkg::TIME_BITS'(prod2));

  always_comb begin
    latch_d = latch_q;
    time_d  = time_q;
    pre1_d  = pre1_q;
    pre2_d  = pre2_q;
    on1_d   = on1_q;
    on2_d   = on2_q;
    exp1_d  = exp1_q;
    exp2_d  = exp2_q;
    res     = '0;
    case (fmtsr_pkg::mode_e'(item_i.mode))
      fmtsr_pkg::MODE_ADDR: begin
        latch_d = {1'b0, b};
      end
      fmtsr_pkg::MODE_ADDR_HI: begin
        latch_d = {1'b0, b} | fmtsr_pkg::REG_HI_BANK;
      end
      fmtsr_pkg::MODE_DATA: begin
        if (latch_q == fmtsr_pkg::REG_T1_PRESET) begin
          pre1_d = b;
          if (on1_q) exp1_d = new_exp1;
        end else if (latch_q == fmtsr_pkg::REG_T2_PRESET) begin
          pre2_d = b;
          if (on2_q) exp2_d = new_exp2;
        end else if (latch_q == fmtsr_pkg::REG_TIMER_CTL) begin
          if (b[fmtsr_pkg::CTL_STOP_BIT]) begin
            on1_d = 1'b0;
            on2_d = 1'b0;
          end else begin
            if (!b[fmtsr_pkg::CTL_T1_MASK]) begin
              on1_d = b[fmtsr_pkg::CTL_T1_ENABLE];
              if (on1_d) exp1_d = new_exp1;
            end
            if (!b[fmtsr_pkg::CTL_T2_MASK]) begin
              on2_d = b[fmtsr_pkg::CTL_T2_ENABLE];
              if (on2_d) exp2_d = new_exp2;
            end
          end
        end else begin
          res.forward_valid    = 1'b1;
          res.forward_register = latch_q;
          res.forward_data     = b;
        end
      end
      fmtsr_pkg::MODE_STATUS: begin
        if (on1_q && (time_q > exp1_q)) begin
          res.read_data = res.read_data | fmtsr_pkg::STS_IRQ | fmtsr_pkg::STS_T1_FLAG;
        end
        if (on2_q && (time_q > exp2_q)) begin
          res.read_data = res.read_data | fmtsr_pkg::STS_IRQ | fmtsr_pkg::STS_T2_FLAG;
        end
      end
      fmtsr_pkg::MODE_READ_HI: begin
        res.read_data = fmtsr_pkg::HI_READ_VAL;
      end
      fmtsr_pkg::MODE_TICK: begin
        time_d = fmtsr_pkg::sat_add(time_q,
                   fmtsr_pkg::TIME_BITS'(item_i.elapsed_us));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per1_q <= fmtsr_pkg::T1_PERIOD_RST;
      per2_q <= fmtsr_pkg::T2_PERIOD_RST;
    end else if (cfg_i.wr) begin
      if (cfg_i.index == fmtsr_pkg::CFG_T1_PERIOD) per1_q <= cfg_i.data;
      if (cfg_i.index == fmtsr_pkg::CFG_T2_PERIOD) per2_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      time_q  <= '0;
      pre1_q  <= '0;
      pre2_q  <= '0;
      on1_q   <= 1'b0;
      on2_q   <= 1'b0;
      exp1_q  <= '0;
      exp2_q  <= '0;
    end else if (step_i) begin
      latch_q <= latch_d;
      time_q  <= time_d;
      pre1_q  <= pre1_d;
      pre2_q  <= pre2_d;
      on1_q   <= on1_d;
      on2_q   <= on2_d;
      exp1_q  <= exp1_d;
      exp2_q  <= exp2_d;
    end
  end

  assign result_o = res;

endmodule

### rtl/core/fmtsr_out_stage.sv
// ----------------------------------------------------------------------------
// fmtsr_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module fmtsr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  fmtsr_pkg::result_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fmtsr_pkg::result_t result_o
);

  logic               valid_q, valid_d;
  fmtsr_pkg::result_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### rtl/core/fm_chip_timer_status_registers_unit.sv
// ----------------------------------------------------------------------------
// fm_chip_timer_status_registers_unit
// FM chip timer and status registers; one transaction a cycle unless stalled.
// Path: input register, then result register when that register is free.
// Throughput: one transaction per cycle while out_ready_i holds high.
// Reset: asynchronous, clears all timer state and time; periods go to 80/320.
// ----------------------------------------------------------------------------
module fm_chip_timer_status_registers_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fmtsr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fmtsr_pkg::PERIOD_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           mode_i,
  input  logic [fmtsr_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic [fmtsr_pkg::PERIOD_W-1:0]       elapsed_us_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fmtsr_pkg::BYTE_W-1:0]         read_data_o,
  output logic                                 forward_valid_o,
  output logic [fmtsr_pkg::REG_W-1:0]          forward_register_o,
  output logic [fmtsr_pkg::BYTE_W-1:0]         forward_data_o
);

  fmtsr_pkg::item_t   in_item, cur_item;
  fmtsr_pkg::result_t core_res, out_res;
  fmtsr_pkg::cfg_wr_t cfg;
  logic               cur_valid, out_free, step;

  assign cfg_ready_o = 1'b1;
  assign cfg.wr      = cfg_valid_i && cfg_ready_o;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  assign in_item.mode       = mode_i;
  assign in_item.data_byte  = data_byte_i;
  assign in_item.elapsed_us = elapsed_us_i;

  assign step = cur_valid && out_free;

  fmtsr_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .consume_i    (step),
    .item_valid_o (cur_valid),
    .item_o       (cur_item)
  );

  fmtsr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (cur_item),
    .result_o (core_res)
  );

  fmtsr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign read_data_o        = out_res.read_data;
  assign forward_valid_o    = out_res.forward_valid;
  assign forward_register_o = out_res.forward_register;
  assign forward_data_o     = out_res.forward_data;

endmodule

### rtl/core/fmtsr_checker.sv
// ----------------------------------------------------------------------------
// fmtsr_checker
// Port-level checks on result transactions of the timer/status unit.
// ----------------------------------------------------------------------------
module fmtsr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [fmtsr_pkg::BYTE_W-1:0] read_data_o,
  input logic                         forward_valid_o,
  input logic [fmtsr_pkg::REG_W-1:0]  forward_register_o,
  input logic [fmtsr_pkg::BYTE_W-1:0] forward_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(forward_valid_o) && $stable(forward_register_o)
      && $stable(forward_data_o))
    else $error("result changed while stalled");

  a_fwd_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && forward_valid_o |-> read_data_o == '0)
    else $error("forwarded write carries read data");

  a_fwd_not_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && forward_valid_o |->
      forward_register_o != fmtsr_pkg::REG_T1_PRESET
      && forward_register_o != fmtsr_pkg::REG_T2_PRESET
      && forward_register_o != fmtsr_pkg::REG_TIMER_CTL)
    else $error("timer register write was forwarded");

  a_no_fwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !forward_valid_o |->
      forward_register_o == '0 && forward_data_o == '0)
    else $error("forward fields set without forward_valid");

  a_status_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_data_o != '0 |-> read_data_o[7])
    else $error("read data without status summary bit");

endmodule

bind fm_chip_timer_status_registers_unit fmtsr_checker u_fmtsr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .read_data_o        (read_data_o),
  .forward_valid_o    (forward_valid_o),
  .forward_register_o (forward_register_o),
  .forward_data_o     (forward_data_o)
);
